// File: src/assert_macros.svh
// assertion macros used by the core rtl file of the ir carrier envelope block
// no dependencies; clock and reset are passed in by the caller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: src/nec_ir_pkg.sv
// shared types and constants for the nec ir carrier envelope block
// no dependencies; used by nec_ir_bit_locate and the top level
package nec_ir_pkg;

	localparam int unsigned PAYLOAD_W  = 32;
	localparam int unsigned NUM_CODES  = 4;
	localparam int unsigned BITNO_W    = 5;
	localparam int unsigned BODY_W     = 16;
	localparam int unsigned START_W    = 17;

	// frame timing in microseconds
	localparam logic [31:0] LEADER_MARK_END  = 32'd9000;
	localparam logic [31:0] LEADER_SPACE_END = 32'd13500;
	localparam logic [31:0] TRAILER_START    = 32'd67420;
	localparam logic [31:0] FRAME_END        = 32'd67980;
	localparam int unsigned BIT_PERIOD_ZERO  = 1120;
	localparam int unsigned ONE_EXTRA        = 1130;
	localparam logic [START_W-1:0] BIT_MARK  = 17'd560;

	// segment codes
	localparam logic [2:0] SEG_LEADER_MARK  = 3'd0;
	localparam logic [2:0] SEG_LEADER_SPACE = 3'd1;
	localparam logic [2:0] SEG_DATA         = 3'd2;
	localparam logic [2:0] SEG_TRAILER      = 3'd3;
	localparam logic [2:0] SEG_COMPLETE     = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_PAYLOAD_CODE0 = 2'd0;
	localparam logic [1:0] REG_PAYLOAD_CODE1 = 2'd1;
	localparam logic [1:0] REG_PAYLOAD_CODE2 = 2'd2;
	localparam logic [1:0] REG_PAYLOAD_CODE3 = 2'd3;

	localparam logic [31:0] PAYLOAD_CODE0_RST = 32'hEF10FF00;
	localparam logic [31:0] PAYLOAD_CODE1_RST = 32'hEE11FF00;
	localparam logic [31:0] PAYLOAD_CODE2_RST = 32'hED12FF00;
	localparam logic [31:0] PAYLOAD_CODE3_RST = 32'hEC13FF00;

	typedef struct packed {
		logic               carrier_on;
		logic [BITNO_W-1:0] bit_number;
	} bit_info_t;

endpackage

// File: src/nec_ir_bit_locate.sv
// finds the payload bit in progress and the carrier state inside the data segment
// depends on nec_ir_pkg
module nec_ir_bit_locate (
	input  logic [nec_ir_pkg::PAYLOAD_W-1:0] payload,
	input  logic [nec_ir_pkg::BODY_W-1:0]    body,
	output nec_ir_pkg::bit_info_t            info
);

	localparam int unsigned NB = nec_ir_pkg::PAYLOAD_W;
	localparam int unsigned SW = nec_ir_pkg::START_W;

	logic [SW-1:0] start_k [NB];
	logic [NB-1:0] reached;
	logic [SW-1:0] body_ext;
	logic [SW-1:0] start_sel;
	logic [SW-1:0] into_bit;
	logic [nec_ir_pkg::BITNO_W-1:0] bitno;

	assign body_ext = {1'b0, body};

	// start offset of every bit from the ones below it, all in parallel
	for (genvar k = 0; k < NB; k++) begin : g_start
		localparam logic [NB-1:0] MASK = (NB'(1) << k) - NB'(1);
		localparam logic [SW-1:0] BASE = SW'(k * nec_ir_pkg::BIT_PERIOD_ZERO);
		logic [5:0] ones_below;
		assign ones_below = 6'($countones(payload & MASK));
		assign start_k[k] = BASE + SW'(ones_below) * SW'(nec_ir_pkg::ONE_EXTRA);
		assign reached[k] = body_ext >= start_k[k];
	end

	// starts rise strictly, so the bit number is the count of bits reached past bit 0
	assign bitno     = nec_ir_pkg::BITNO_W'($countones(reached[NB-1:1]));
	assign start_sel = start_k[bitno];
	assign into_bit  = body_ext - start_sel;

	assign info.carrier_on = into_bit < nec_ir_pkg::BIT_MARK;
	assign info.bit_number = bitno;

endmodule

// File: src/nec_ir_carrier_envelope_core.sv
// path: a request passes through the input register, then the result register, before its
// result is offered on the result stream
// throughput: one request per cycle; ready falls only when the result register stalls
// reset: arst_n asynchronous active low clears both stage valids and loads the
// four payload registers with their default codes
// depends on nec_ir_pkg, nec_ir_bit_locate and assert_macros.svh
`include "assert_macros.svh"

module nec_ir_carrier_envelope_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [1:0] code_index, [33:2] elapsed_us, rest zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] carrier_on, [3:1] segment, [8:4] bit_number, rest zero
);

	logic [31:0] payload_q [nec_ir_pkg::NUM_CODES];

	logic        valid_s1;
	logic [1:0]  code_s1;
	logic [31:0] elapsed_s1;

	logic        valid_s2;
	logic        carrier_s2;
	logic [2:0]  segment_s2;
	logic [4:0]  bitno_s2;

	logic        adv_s2;
	logic        adv_s1;

	logic [nec_ir_pkg::BODY_W-1:0] body;
	nec_ir_pkg::bit_info_t         info;
	logic        carrier_c;
	logic [2:0]  segment_c;
	logic [4:0]  bitno_c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_q[0] <= nec_ir_pkg::PAYLOAD_CODE0_RST;
			payload_q[1] <= nec_ir_pkg::PAYLOAD_CODE1_RST;
			payload_q[2] <= nec_ir_pkg::PAYLOAD_CODE2_RST;
			payload_q[3] <= nec_ir_pkg::PAYLOAD_CODE3_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				nec_ir_pkg::REG_PAYLOAD_CODE0: payload_q[0] <= cfg_data;
				nec_ir_pkg::REG_PAYLOAD_CODE1: payload_q[1] <= cfg_data;
				nec_ir_pkg::REG_PAYLOAD_CODE2: payload_q[2] <= cfg_data;
				nec_ir_pkg::REG_PAYLOAD_CODE3: payload_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			code_s1    <= s_tdata[1:0];
			elapsed_s1 <= s_tdata[33:2];
		end
	end

	// offset into the data bits; only meaningful inside the data segment
	assign body = nec_ir_pkg::BODY_W'(elapsed_s1 - nec_ir_pkg::LEADER_SPACE_END);

	nec_ir_bit_locate u_locate (
		.payload (payload_q[code_s1]),
		.body    (body),
		.info    (info)
	);

	always_comb begin
		carrier_c = 1'b0;
		segment_c = nec_ir_pkg::SEG_DATA;
		bitno_c   = '0;
		priority if (elapsed_s1 < nec_ir_pkg::LEADER_MARK_END) begin
			carrier_c = 1'b1;
			segment_c = nec_ir_pkg::SEG_LEADER_MARK;
		end else if (elapsed_s1 < nec_ir_pkg::LEADER_SPACE_END) begin
			segment_c = nec_ir_pkg::SEG_LEADER_SPACE;
		end else if (elapsed_s1 >= nec_ir_pkg::FRAME_END) begin
			segment_c = nec_ir_pkg::SEG_COMPLETE;
		end else if (elapsed_s1 >= nec_ir_pkg::TRAILER_START) begin
			carrier_c = 1'b1;
			segment_c = nec_ir_pkg::SEG_TRAILER;
		end else begin
			carrier_c = info.carrier_on;
			bitno_c   = info.bit_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			carrier_s2 <= carrier_c;
			segment_s2 <= segment_c;
			bitno_s2   <= bitno_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, bitno_s2, segment_s2, carrier_s2};

	`ASSERT_IMPL(a_bitno_outside_data, clk, arst_n,
		m_tvalid && (m_tdata[3:1] != nec_ir_pkg::SEG_DATA), m_tdata[8:4] == 5'd0,
		"bit number set outside data segment")
	`ASSERT_IMPL(a_complete_dark, clk, arst_n,
		m_tvalid && (m_tdata[3:1] == nec_ir_pkg::SEG_COMPLETE), !m_tdata[0],
		"carrier on after frame end")
	`ASSERT_NEXT(a_s1_held_on_stall, clk, arst_n,
		valid_s1 && !adv_s2, valid_s1 && $stable(elapsed_s1) && $stable(code_s1),
		"input stage lost a request while the result stalled")

endmodule
